### sv/assert_macros.svh
// ----------------------------------------------------------------------------
// assertion macros
// shared concurrent assertion forms for the command stream parser
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked outside reset
`define ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("implication check failed");

// next-cycle implication, checked outside reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

### sv/vcsp_pkg.sv
// ----------------------------------------------------------------------------
// vcsp_pkg
// types, command codes and decode tables of the command stream parser
// ----------------------------------------------------------------------------
`default_nettype none

package vcsp_pkg;

    typedef enum logic [2:0] {
        PH_CMD,
        PH_OPER,
        PH_HDR,
        PH_SIZE,
        PH_SKIP
    } phase_t;

    typedef enum logic [2:0] {
        KIND_PSG     = 3'd0,
        KIND_FM      = 3'd1,
        KIND_WAVE    = 3'd2,
        KIND_WAIT    = 3'd3,
        KIND_END     = 3'd4,
        KIND_UNKNOWN = 3'd5,
        KIND_BADPORT = 3'd6
    } kind_t;

    typedef struct packed {
        kind_t       kind;
        logic [15:0] write_address;
        logic [7:0]  write_data;
        logic [31:0] wait_total;
        logic [15:0] repeat_total;
    } result_t;

    localparam logic [7:0] CMD_PSG_A     = 8'h50;
    localparam logic [7:0] CMD_FM        = 8'h51;
    localparam logic [7:0] CMD_PSG_B     = 8'hA0;
    localparam logic [7:0] CMD_WAIT_N    = 8'h61;
    localparam logic [7:0] CMD_WAIT_NTSC = 8'h62;
    localparam logic [7:0] CMD_WAIT_PAL  = 8'h63;
    localparam logic [7:0] CMD_END       = 8'h66;
    localparam logic [7:0] CMD_BLOCK     = 8'h67;
    localparam logic [7:0] CMD_BLOCK_PCM = 8'h68;
    localparam logic [7:0] CMD_WAVE      = 8'hD2;

    localparam logic [3:0] NIB_WAIT_SHORT = 4'h7;
    localparam logic [3:0] NIB_WAIT_ZERO  = 4'h8;

    localparam logic [31:0] WAIT_NTSC = 32'd735;
    localparam logic [31:0] WAIT_PAL  = 32'd882;

    localparam logic [31:0] HDR_LEN_BLOCK     = 32'd2;
    localparam logic [31:0] HDR_LEN_BLOCK_PCM = 32'd8;

    localparam logic [7:0] WAVE_PORT_MAX = 8'd5;

    // base address of each wavetable port
    function automatic logic [15:0] wave_base(input logic [2:0] port);
        logic [15:0] base;
        unique case (port)
            3'd0:    base = 16'h9800;
            3'd1:    base = 16'h9880;
            3'd2:    base = 16'h988A;
            3'd3:    base = 16'h988F;
            3'd4:    base = 16'h9800;
            3'd5:    base = 16'h98C0;
            default: base = 16'h0000;
        endcase
        return base;
    endfunction

    // operand bytes silently skipped after a fixed-length command, zero if none
    function automatic logic [3:0] skip_length(input logic [7:0] c);
        logic [3:0] n;
        priority if (c >= 8'h30 && c <= 8'h3F) n = 4'd1;
        else if (c == 8'h4F || c == 8'h94)     n = 4'd1;
        else if (c >= 8'h40 && c <= 8'h4E)     n = 4'd2;
        else if (c >= 8'h52 && c <= 8'h5F)     n = 4'd2;
        else if (c >= 8'hA1 && c <= 8'hBF)     n = 4'd2;
        else if (c == 8'h90 || c == 8'h91 || c == 8'h95) n = 4'd4;
        else if (c == 8'h92)                   n = 4'd5;
        else if (c == 8'h93)                   n = 4'd10;
        else if (c >= 8'hC0 && c <= 8'hDF && c != CMD_WAVE) n = 4'd3;
        else if (c >= 8'hE0)                   n = 4'd4;
        else                                   n = 4'd0;
        return n;
    endfunction

endpackage

`default_nettype wire

### sv/vgm_command_stream_parser.sv
// ----------------------------------------------------------------------------
// vgm_command_stream_parser
// decodes the command bytes of a sound log into chip writes, waits and ends
// ----------------------------------------------------------------------------
// input channel: in_valid / in_stall carry one request of mode and stream_byte;
//   mode high restarts the parser and clears the wait total and pass count
// output channel: out_valid / out_stall carry kind, write_address, write_data,
//   wait_total and repeat_total; a byte yields zero or one result
// timing: a result is registered in the output register, or in the skid entry
//   while the output is stalled; one byte is taken every cycle while in_stall is low,
//   the decode, the wait adder and the operand count all settle in the cycle the byte is taken
// the output register is backed by one skid entry, so bytes keep flowing while
//   a result waits; in_stall rises only when both entries hold results
// reset: parser returns to the command phase, wait total and pass count clear,
//   both result entries empty; no clearing pass
// a stalled result holds its fields until taken
// ----------------------------------------------------------------------------
`default_nettype none

module vgm_command_stream_parser (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic        mode,
    input  wire logic [7:0]  stream_byte,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [2:0]       kind,
    output logic [15:0]      write_address,
    output logic [7:0]       write_data,
    output logic [31:0]      wait_total,
    output logic [15:0]      repeat_total
);

    vcsp_pkg::phase_t  phase_reg, phase_next;
    logic [7:0]        cmd_reg, cmd_next;
    logic [1:0]        cnt_reg, cnt_next;
    logic [7:0]        oper_reg [2];
    logic [31:0]       skip_reg, skip_next;
    logic [31:0]       wait_reg, wait_next;
    logic [15:0]       pass_reg, pass_next;

    vcsp_pkg::result_t out_reg, skid_reg, res;
    logic              out_valid_reg, skid_valid_reg;
    logic              has_res;
    logic              oper_we;
    logic              do_wait;
    logic [31:0]       addend;
    logic [31:0]       size_val;
    logic [3:0]        skip_len;
    logic              in_acc, out_take;

    assign in_stall = skid_valid_reg;
    assign in_acc   = in_valid && !in_stall;
    assign out_take = out_valid_reg && !out_stall;
    assign skip_len = vcsp_pkg::skip_length(stream_byte);

    always_comb
    begin
        phase_next = phase_reg;
        cmd_next   = cmd_reg;
        cnt_next   = cnt_reg;
        skip_next  = skip_reg;
        wait_next  = wait_reg;
        pass_next  = pass_reg;
        has_res    = 1'b0;
        oper_we    = 1'b0;
        do_wait    = 1'b0;
        addend     = '0;
        size_val   = '0;
        res.kind          = vcsp_pkg::KIND_PSG;
        res.write_address = '0;
        res.write_data    = '0;

        if (mode)
        begin
            phase_next = vcsp_pkg::PH_CMD;
            cmd_next   = '0;
            cnt_next   = '0;
            skip_next  = '0;
            wait_next  = '0;
            pass_next  = '0;
        end
        else
        begin
            unique case (phase_reg)
                vcsp_pkg::PH_OPER:
                begin
                    oper_we  = 1'b1;
                    cnt_next = cnt_reg + 2'd1;
                    if ((cmd_reg == vcsp_pkg::CMD_WAVE) ? (cnt_reg == 2'd2) : (cnt_reg == 2'd1))
                    begin
                        phase_next = vcsp_pkg::PH_CMD;
                        cnt_next   = '0;
                        has_res    = 1'b1;
                        priority if (cmd_reg == vcsp_pkg::CMD_WAIT_N)
                        begin
                            do_wait  = 1'b1;
                            addend   = {16'h0000, stream_byte, oper_reg[0]};
                            res.kind = vcsp_pkg::KIND_WAIT;
                        end
                        else if (cmd_reg == vcsp_pkg::CMD_FM)
                        begin
                            res.kind          = vcsp_pkg::KIND_FM;
                            res.write_address = {8'h00, oper_reg[0]};
                            res.write_data    = stream_byte;
                        end
                        else if (cmd_reg == vcsp_pkg::CMD_WAVE)
                        begin
                            if (oper_reg[0] > vcsp_pkg::WAVE_PORT_MAX)
                            begin
                                res.kind = vcsp_pkg::KIND_BADPORT;
                            end
                            else
                            begin
                                res.kind          = vcsp_pkg::KIND_WAVE;
                                res.write_address = vcsp_pkg::wave_base(oper_reg[0][2:0])
                                                    + {8'h00, oper_reg[1]};
                                res.write_data    = stream_byte;
                            end
                        end
                        else
                        begin
                            res.kind          = vcsp_pkg::KIND_PSG;
                            res.write_address = {8'h00, oper_reg[0]};
                            res.write_data    = stream_byte;
                        end
                    end
                end
                vcsp_pkg::PH_HDR:
                begin
                    skip_next = skip_reg - 32'd1;
                    if (skip_reg == 32'd1)
                    begin
                        phase_next = vcsp_pkg::PH_SIZE;
                        cnt_next   = '0;
                    end
                end
                vcsp_pkg::PH_SIZE:
                begin
                    // size arrives little-endian, low byte first
                    size_val  = skip_reg | ({24'h000000, stream_byte} << {cnt_reg, 3'b000});
                    skip_next = size_val;
                    cnt_next  = cnt_reg + 2'd1;
                    if ((cmd_reg == vcsp_pkg::CMD_BLOCK) ? (cnt_reg == 2'd3) : (cnt_reg == 2'd2))
                    begin
                        // second-chip flag in bit 31 is not part of the length
                        if (cmd_reg == vcsp_pkg::CMD_BLOCK)
                        begin
                            size_val[31] = 1'b0;
                        end
                        skip_next  = size_val;
                        cnt_next   = '0;
                        phase_next = (size_val == 32'd0) ? vcsp_pkg::PH_CMD
                                                         : vcsp_pkg::PH_SKIP;
                    end
                end
                vcsp_pkg::PH_SKIP:
                begin
                    skip_next = skip_reg - 32'd1;
                    if (skip_reg == 32'd1)
                    begin
                        phase_next = vcsp_pkg::PH_CMD;
                    end
                end
                default:
                begin
                    cmd_next = stream_byte;
                    cnt_next = '0;
                    priority if (stream_byte == vcsp_pkg::CMD_PSG_A
                                 || stream_byte == vcsp_pkg::CMD_FM
                                 || stream_byte == vcsp_pkg::CMD_PSG_B
                                 || stream_byte == vcsp_pkg::CMD_WAIT_N
                                 || stream_byte == vcsp_pkg::CMD_WAVE)
                    begin
                        phase_next = vcsp_pkg::PH_OPER;
                    end
                    else if (stream_byte == vcsp_pkg::CMD_WAIT_NTSC)
                    begin
                        do_wait = 1'b1;
                        addend  = vcsp_pkg::WAIT_NTSC;
                    end
                    else if (stream_byte == vcsp_pkg::CMD_WAIT_PAL)
                    begin
                        do_wait = 1'b1;
                        addend  = vcsp_pkg::WAIT_PAL;
                    end
                    else if (stream_byte[7:4] == vcsp_pkg::NIB_WAIT_SHORT)
                    begin
                        do_wait = 1'b1;
                        addend  = {28'h0000000, stream_byte[3:0]} + 32'd1;
                    end
                    else if (stream_byte[7:4] == vcsp_pkg::NIB_WAIT_ZERO)
                    begin
                        do_wait = 1'b1;
                        addend  = {28'h0000000, stream_byte[3:0]};
                    end
                    else if (stream_byte == vcsp_pkg::CMD_END)
                    begin
                        has_res   = 1'b1;
                        res.kind  = vcsp_pkg::KIND_END;
                        wait_next = '0;
                        if (pass_reg != 16'hFFFF)
                        begin
                            pass_next = pass_reg + 16'd1;
                        end
                    end
                    else if (stream_byte == vcsp_pkg::CMD_BLOCK
                             || stream_byte == vcsp_pkg::CMD_BLOCK_PCM)
                    begin
                        skip_next  = (stream_byte == vcsp_pkg::CMD_BLOCK)
                                     ? vcsp_pkg::HDR_LEN_BLOCK
                                     : vcsp_pkg::HDR_LEN_BLOCK_PCM;
                        phase_next = vcsp_pkg::PH_HDR;
                    end
                    else if (skip_len != 4'd0)
                    begin
                        skip_next  = {28'h0000000, skip_len};
                        phase_next = vcsp_pkg::PH_SKIP;
                    end
                    else
                    begin
                        has_res  = 1'b1;
                        res.kind = vcsp_pkg::KIND_UNKNOWN;
                    end
                    if (do_wait)
                    begin
                        has_res  = 1'b1;
                        res.kind = vcsp_pkg::KIND_WAIT;
                    end
                end
            endcase
        end

        if (do_wait)
        begin
            wait_next = wait_reg + addend;
        end
        res.wait_total   = wait_next;
        res.repeat_total = pass_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= vcsp_pkg::PH_CMD;
            cmd_reg   <= '0;
            cnt_reg   <= '0;
            skip_reg  <= '0;
            wait_reg  <= '0;
            pass_reg  <= '0;
        end
        else if (in_acc)
        begin
            phase_reg <= phase_next;
            cmd_reg   <= cmd_next;
            cnt_reg   <= cnt_next;
            skip_reg  <= skip_next;
            wait_reg  <= wait_next;
            pass_reg  <= pass_next;
        end
    end

    // operand bytes, only the first two are ever read back
    always_ff @(posedge clk)
    begin
        if (in_acc && oper_we && !mode && !cnt_reg[1])
        begin
            oper_reg[cnt_reg[0]] <= stream_byte;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (out_take)
            begin
                skid_valid_reg <= 1'b0;
            end
        end
        else if (in_acc && has_res)
        begin
            if (out_valid_reg && !out_take)
            begin
                skid_valid_reg <= 1'b1;
            end
            else
            begin
                out_valid_reg <= 1'b1;
            end
        end
        else if (out_take)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (out_take)
            begin
                out_reg <= skid_reg;
            end
        end
        else if (in_acc && has_res)
        begin
            if (out_valid_reg && !out_take)
            begin
                skid_reg <= res;
            end
            else
            begin
                out_reg <= res;
            end
        end
    end

    assign out_valid     = out_valid_reg;
    assign kind          = out_reg.kind;
    assign write_address = out_reg.write_address;
    assign write_data    = out_reg.write_data;
    assign wait_total    = out_reg.wait_total;
    assign repeat_total  = out_reg.repeat_total;

`include "assert_macros.svh"

    `ASSERT_IMP(a_skid_behind_out, clk, rst_n, skid_valid_reg, out_valid_reg)
    `ASSERT_IMP(a_skip_nonzero, clk, rst_n, phase_reg == vcsp_pkg::PH_SKIP, skip_reg != 32'd0)
    `ASSERT_IMP(a_hdr_range, clk, rst_n, phase_reg == vcsp_pkg::PH_HDR, (skip_reg != 32'd0) && (skip_reg <= vcsp_pkg::HDR_LEN_BLOCK_PCM))
    `ASSERT_NEXT(a_restart_clears, clk, rst_n, in_acc && mode, (phase_reg == vcsp_pkg::PH_CMD) && (wait_reg == 32'd0) && (pass_reg == 16'd0))

endmodule

`default_nettype wire
